@@ hdl/vector3_normalize_rsqrt_unit_defines.svh @@
// Assertion macros for the vector normalize unit
`ifndef VECTOR3_NORMALIZE_RSQRT_UNIT_DEFINES_SVH
`define VECTOR3_NORMALIZE_RSQRT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define VNR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vnr: implication violated");

`define VNR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vnr: next-cycle check violated");

`define VNR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("vnr: forbidden condition seen");

`else

`define VNR_ASSERT_IMPL(lbl, ante, cons)

`define VNR_ASSERT_NEXT(lbl, ante, cons)

`define VNR_ASSERT_NEVER(lbl, cond)

`endif

`endif

@@ hdl/vnr_pkg.sv @@
// Shared constants and seed table function for the vector normalize unit
`timescale 1ns / 1ps

package vnr_pkg;

  localparam int SEED_BITS_DEF  = 8;
  localparam int COMP_WIDTH_DEF = 16;

  localparam int SEED_W     = 17;          // seed, unsigned Q1.16
  localparam int Y1_W       = SEED_W + 1;  // refined estimate
  localparam int M_W        = 32;          // mantissa, unsigned Q2.30
  localparam int M_FRAC     = 30;
  localparam int OUT_W      = 16;
  localparam int CFG_W      = 32;
  localparam int NUM_STAGES = 11;

  localparam logic [CFG_W-1:0] MIN_LEN_RST = 32'd1;
  localparam logic [M_W-1:0]   THREE_Q30   = 32'hC000_0000;
  localparam int SAT_POS_MAG = 32767;
  localparam int SAT_NEG_MAG = 32768;

  // floor(sqrt(floor(2^(sb+31) / (2*idx+1)))) found bit by bit:
  // r*r <= floor(N/d) holds exactly when r*r*d <= N.
  function automatic logic [SEED_W-1:0] seed_entry(input int unsigned idx,
                                                   input int unsigned sb);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] r;
    logic [63:0] trial;
    num = 64'd1 << (sb + 31);
    den = 64'(2 * idx + 1);
    r   = '0;
    for (int k = SEED_W - 1; k >= 0; k--) begin
      trial = r | (64'd1 << k);
      if (trial * trial * den <= num) begin
        r = trial;
      end
    end
    return r[SEED_W-1:0];
  endfunction

endpackage

@@ hdl/vector3_normalize_rsqrt_unit.sv @@
// Vector normalizer: squared length, seed table, Newton step and scaling in one pipeline
`timescale 1ns / 1ps
`include "vector3_normalize_rsqrt_unit_defines.svh"

// Takes a signed vector (comp_x/y/z) on the input channel and returns the unit
// vector in Q1.15 on the output channel, rounded and saturated, with too_short
// set (and a zero vector) when the squared length is zero or below min_length.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// min_length is written through cfg_we_i/cfg_wdata_i; the user must do so only
// while the unit is idle, as the unit itself does not enforce it.
// Pipeline: 11 register stages (capture, square, sum and compare, leading-one
// search, normalizing shift, seed table, seed square, mantissa product,
// Newton step, component product, round and saturate). One beat per cycle is
// taken for as long as the receiver keeps up.
// Each stage holds a valid bit and only stalls when full and its successor
// stalls, so bubbles close up and input keeps flowing while the output
// register waits on a stalled receiver; in_ready_o drops once every stage
// is full. Nothing is lost or repeated over a stall.
// Reset clears all valid bits and loads min_length with 1; the unit accepts
// beats straight after reset.
module vector3_normalize_rsqrt_unit
  import vnr_pkg::*;
#(
  parameter int SEED_BITS  = SEED_BITS_DEF,
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COMP_WIDTH-1:0] comp_x_i,
  input  logic signed [COMP_WIDTH-1:0] comp_y_i,
  input  logic signed [COMP_WIDTH-1:0] comp_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [OUT_W-1:0]      unit_x_o,
  output logic signed [OUT_W-1:0]      unit_y_o,
  output logic signed [OUT_W-1:0]      unit_z_o,
  output logic                         too_short_o
);

  localparam int CW    = COMP_WIDTH;
  localparam int SQ_W  = 2 * CW - 1;
  localparam int S_W   = 2 * CW;
  localparam int CMP_W = (S_W > CFG_W) ? S_W : CFG_W;
  localparam int B_W   = $clog2(S_W);
  localparam int Q_W   = B_W - 1;
  localparam int E_W   = S_W + M_FRAC;
  localparam int ROM_D = 1 << SEED_BITS;
  localparam int P_W   = CW + Y1_W;
  localparam int R_W   = P_W + 1;
  localparam int NS    = NUM_STAGES;

  // ---------------------------------------------------------------------------
  // Seed table
  // ---------------------------------------------------------------------------
  logic [SEED_W-1:0] seed_rom [ROM_D];

  for (genvar g = 0; g < ROM_D; g++) begin : g_rom
    localparam logic [SEED_W-1:0] Entry = seed_entry(g, SEED_BITS);
    assign seed_rom[g] = Entry;
  end

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] min_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_q, v_d, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic [2:0][CW-1:0]   c0_q;
  logic [2:0][SQ_W-1:0] sq1_q;
  logic [S_W-1:0]       s2_q, s3_q;
  logic [B_W-1:0]       b3_q;
  logic [M_W-1:0]       m4_q, m5_q, m6_q;
  logic [SEED_W-1:0]    y0_5_q, y0_6_q, y0_7_q;
  logic [M_W-1:0]       t6_q, u7_q;
  logic [Y1_W-1:0]      y1_8_q;
  logic [2:0][P_W-1:0]  prod9_q;
  logic [2:0][OUT_W-1:0] unit10_q;

  // side-band travelling with each beat
  logic [2:0][CW-1:0] mag_q   [1:8];
  logic [2:0]         neg_q   [1:9];
  logic               short_q [2:10];
  logic [Q_W-1:0]     q_q     [4:9];

  // combinational per-stage results
  logic [2:0][CW-1:0]    mag_d;
  logic [2:0]            neg_d;
  logic [2:0][SQ_W-1:0]  sq_d;
  logic [S_W-1:0]        s_d;
  logic                  short_d;
  logic [B_W-1:0]        b_d;
  logic [B_W-1:0]        sh_amt;
  logic [E_W-1:0]        norm;
  logic [SEED_W-1:0]     y0_d;
  logic [2*SEED_W-1:0]   t_full;
  logic [2*M_W-1:0]      u_full;
  logic [M_W-1:0]        h_d;
  logic [SEED_W+M_W-1:0] y1_full;
  logic [2:0][P_W-1:0]   prod_d;
  logic [R_W-1:0]        rnd  [3];
  logic [R_W-1:0]        rmag [3];
  logic [2:0][OUT_W-1:0] unit_d;

  // stage 1: sign, magnitude, square
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      neg_d[j] = c0_q[j][CW-1];
      mag_d[j] = neg_d[j] ? (CW'(0) - c0_q[j]) : c0_q[j];
      sq_d[j]  = SQ_W'(mag_d[j] * mag_d[j]);
    end
  end

  // stage 2: squared length and lower limit
  always_comb begin
    s_d     = S_W'(sq1_q[0]) + S_W'(sq1_q[1]) + S_W'(sq1_q[2]);
    short_d = (s_d == '0) || (CMP_W'(s_d) < CMP_W'(min_len_q));
  end

  // stage 3: leading one
  always_comb begin
    b_d = '0;
    for (int i = 0; i < S_W; i++) begin
      if (s2_q[i]) begin
        b_d = B_W'(i);
      end
    end
  end

  // stage 4: even shift puts the leading one at bit 30 or 31; q is half the
  // shift seen from the Q2.30 point, which works out to b/2
  always_comb begin
    sh_amt = {b3_q[B_W-1:1], 1'b0};
    norm   = {s3_q, {M_FRAC{1'b0}}} >> sh_amt;
  end

  // stage 5..8: seed, Newton step
  always_comb begin
    y0_d    = seed_rom[m4_q[M_W-1 -: SEED_BITS]];
    t_full  = y0_5_q * y0_5_q;
    u_full  = m6_q * t6_q;
    h_d     = (u7_q > THREE_Q30) ? '0 : (THREE_Q30 - u7_q);
    y1_full = y0_7_q * h_d;
  end

  // stage 9..10: scale, round half up on the magnitude, saturate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_d[j] = P_W'(mag_q[8][j] * y1_8_q);
      rnd[j]    = R_W'(prod9_q[j]) + (R_W'(1) << q_q[9]);
      rmag[j]   = (rnd[j] >> q_q[9]) >> 1;
      if (short_q[9]) begin
        unit_d[j] = '0;
      end else if (neg_q[9][j]) begin
        if (rmag[j] > R_W'(SAT_NEG_MAG)) begin
          unit_d[j] = OUT_W'(SAT_NEG_MAG);
        end else begin
          unit_d[j] = OUT_W'(0) - rmag[j][OUT_W-1:0];
        end
      end else begin
        if (rmag[j] > R_W'(SAT_POS_MAG)) begin
          unit_d[j] = OUT_W'(SAT_POS_MAG);
        end else begin
          unit_d[j] = rmag[j][OUT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c0_q <= {comp_z_i, comp_y_i, comp_x_i};
    end
    if (en[1]) begin
      sq1_q    <= sq_d;
      mag_q[1] <= mag_d;
      neg_q[1] <= neg_d;
    end
    if (en[2]) begin
      s2_q       <= s_d;
      short_q[2] <= short_d;
    end
    if (en[3]) begin
      s3_q <= s2_q;
      b3_q <= b_d;
    end
    if (en[4]) begin
      m4_q   <= norm[M_W-1:0];
      q_q[4] <= b3_q[B_W-1:1];
    end
    if (en[5]) begin
      m5_q   <= m4_q;
      y0_5_q <= y0_d;
    end
    if (en[6]) begin
      m6_q   <= m5_q;
      y0_6_q <= y0_5_q;
      t6_q   <= t_full[M_W-1:0];
    end
    if (en[7]) begin
      u7_q   <= u_full[2*M_W-1:M_W];
      y0_7_q <= y0_6_q;
    end
    if (en[8]) begin
      y1_8_q <= y1_full[SEED_W+M_W-1 -: Y1_W];
    end
    if (en[9]) begin
      prod9_q <= prod_d;
    end
    if (en[10]) begin
      unit10_q <= unit_d;
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) begin
        mag_q[k] <= mag_q[k-1];
      end
    end
    for (int k = 2; k <= 9; k++) begin
      if (en[k]) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
    for (int k = 3; k <= 10; k++) begin
      if (en[k]) begin
        short_q[k] <= short_q[k-1];
      end
    end
    for (int k = 5; k <= 9; k++) begin
      if (en[k]) begin
        q_q[k] <= q_q[k-1];
      end
    end
  end

  assign unit_x_o    = unit10_q[0];
  assign unit_y_o    = unit10_q[1];
  assign unit_z_o    = unit10_q[2];
  assign too_short_o = short_q[10];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // back-pressure reaches the input only once every stage holds a beat
  `VNR_ASSERT_NEVER(a_ready_only_when_full, !in_ready_o && !(&v_q))
  // an accepted beat lands in the capture stage
  `VNR_ASSERT_NEXT(a_accept_lands, in_valid_i && in_ready_o, v_q[0])
  // a short vector always comes out as zero
  `VNR_ASSERT_IMPL(a_short_is_zero, out_valid_o && too_short_o,
                   unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0)

endmodule

@@ bench/vector3_normalize_rsqrt_unit_tb.sv @@
// Self-checking bench for the vector normalize unit: random and corner vectors, scoreboard
`timescale 1ns / 1ps

module vector3_normalize_rsqrt_unit_tb
  import vnr_pkg::*;
();

  localparam int SEED_BITS   = SEED_BITS_DEF;
  localparam int CW          = COMP_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP   = 50;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] ux;
    logic signed [OUT_W-1:0] uy;
    logic signed [OUT_W-1:0] uz;
    logic                    too_short;
  } unit_result_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic signed [CW-1:0]    comp_x_i    = '0;
  logic signed [CW-1:0]    comp_y_i    = '0;
  logic signed [CW-1:0]    comp_z_i    = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] unit_x_o;
  logic signed [OUT_W-1:0] unit_y_o;
  logic signed [OUT_W-1:0] unit_z_o;
  logic                    too_short_o;

  vec_item_t    pending_vectors[$];
  unit_result_t expected_units[$];
  logic [CFG_W-1:0] floor_sq_mirror = MIN_LEN_RST;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  vector3_normalize_rsqrt_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .comp_x_i    (comp_x_i),
    .comp_y_i    (comp_y_i),
    .comp_z_i    (comp_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .unit_x_o    (unit_x_o),
    .unit_y_o    (unit_y_o),
    .unit_z_o    (unit_z_o),
    .too_short_o (too_short_o)
  );

  always #10 clk_i = ~clk_i;

  // floor(sqrt(v)), one result bit per pass from the top
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      trial = r | (64'd1 << k);
      if (trial * trial <= v) begin
        r = trial;
      end
    end
    return r;
  endfunction

  function automatic unit_result_t predict_unit(input vec_item_t v,
                                                input logic [CFG_W-1:0] floor_sq);
    unit_result_t res;
    logic signed [CW-1:0] comp [3];
    logic [63:0] magn [3];
    logic [OUT_W-1:0] outv [3];
    logic [63:0] len_sq, mant, seed, seed_sq, prod, corr, refined, scaled;
    int lead, shamt, q;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    len_sq = '0;
    for (int i = 0; i < 3; i++) begin
      magn[i] = comp[i][CW-1] ? 64'(-int'(comp[i])) : 64'(int'(comp[i]));
      len_sq += magn[i] * magn[i];
    end
    res = '0;
    if (len_sq == 0 || len_sq < {32'd0, floor_sq}) begin
      res.too_short = 1'b1;
      return res;
    end
    lead = 63;
    while (lead > 0 && !len_sq[lead]) lead--;
    // even shift so the exponent halves cleanly
    if (lead >= M_FRAC) begin
      shamt = (lead - M_FRAC) & ~1;
      mant  = len_sq >> shamt;
    end else begin
      shamt = -((M_FRAC - lead + 1) & ~1);
      mant  = len_sq << (-shamt);
    end
    q = 15 + shamt / 2;
    seed    = root_floor((64'd1 << (SEED_BITS + 31)) /
                         (2 * (mant >> (M_W - SEED_BITS)) + 1));
    seed_sq = seed * seed;
    prod    = ({32'd0, mant[31:0]} * {32'd0, seed_sq[31:0]}) >> 32;
    corr    = (prod > {32'd0, THREE_Q30}) ? 64'd0 : {32'd0, THREE_Q30} - prod;
    refined = (seed * corr) >> 31;
    for (int i = 0; i < 3; i++) begin
      scaled = (magn[i] * refined + (64'd1 << q)) >> (q + 1);
      if (comp[i][CW-1]) begin
        if (scaled > SAT_NEG_MAG) scaled = SAT_NEG_MAG;
        outv[i] = OUT_W'(64'd0 - scaled);
      end else begin
        if (scaled > SAT_POS_MAG) scaled = SAT_POS_MAG;
        outv[i] = OUT_W'(scaled);
      end
    end
    res.ux = outv[0];
    res.uy = outv[1];
    res.uz = outv[2];
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rand_comp();
    logic signed [CW-1:0] val;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: val = CW'($urandom);
      4, 5, 6:    val = $signed(CW'($urandom)) >>> $urandom_range(1, CW - 1);
      7:          val = CW'(int'($urandom_range(0, 16)) - 8);
      8: begin
        case ($urandom_range(0, 3))
          0:       val = {1'b1, {(CW-1){1'b0}}};
          1:       val = {1'b0, {(CW-1){1'b1}}};
          2:       val = CW'(1);
          default: val = '1;
        endcase
      end
      default:    val = '0;
    endcase
    return val;
  endfunction

  task automatic report(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic queue_vec(input int x, input int y, input int z);
    vec_item_t it;
    it.x = CW'(x);
    it.y = CW'(y);
    it.z = CW'(z);
    pending_vectors.push_back(it);
  endtask

  task automatic queue_random(input int n);
    vec_item_t it;
    repeat (n) begin
      it.x = rand_comp();
      it.y = rand_comp();
      it.z = rand_comp();
      pending_vectors.push_back(it);
    end
  endtask

  // sender holds off until every beat has gone through and come back
  task automatic wait_drained();
    while (pending_vectors.size() != 0 || expected_units.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_min_length(input logic [CFG_W-1:0] val);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    cfg_wdata_i     <= val;
    floor_sq_mirror  = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      comp_x_i   <= '0;
      comp_y_i   <= '0;
      comp_z_i   <= '0;
    end else begin
      vec_item_t it;
      if (in_valid_i && in_ready_o) begin
        it.x = comp_x_i;
        it.y = comp_y_i;
        it.z = comp_z_i;
        expected_units.push_back(predict_unit(it, floor_sq_mirror));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_vectors.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = pending_vectors.pop_front();
          in_valid_i <= 1'b1;
          comp_x_i   <= it.x;
          comp_y_i   <= it.y;
          comp_z_i   <= it.z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      unit_result_t want;
      if (out_valid_o && out_ready_i) begin
        if (expected_units.size() == 0) begin
          report("unexpected result beat", int'(unit_x_o), 0);
        end else begin
          want = expected_units.pop_front();
          if (unit_x_o !== want.ux) report("unit_x", int'(unit_x_o), int'(want.ux));
          if (unit_y_o !== want.uy) report("unit_y", int'(unit_y_o), int'(want.uy));
          if (unit_z_o !== want.uz) report("unit_z", int'(unit_z_o), int'(want.uz));
          if (too_short_o !== want.too_short) begin
            report("too_short", int'(too_short_o), int'(want.too_short));
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("vector3_normalize_rsqrt_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 35;
    recv_idle_pct = 71;
    // reset minimum of 1: corners, zero length, saturation both ways
    queue_vec(0, 0, 0);
    queue_vec(1, 0, 0);
    queue_vec(-1, 0, 0);
    queue_vec(0, 1, 0);
    queue_vec(0, 0, -1);
    queue_vec(32767, 0, 0);
    queue_vec(-32768, 0, 0);
    queue_vec(0, -32768, 0);
    queue_vec(0, 0, -32768);
    queue_vec(-32768, -32768, -32768);
    queue_vec(32767, 32767, 32767);
    queue_vec(32767, -32768, 1);
    queue_vec(1, 1, 1);
    queue_vec(-1, -1, -1);
    queue_vec(3, 4, 0);
    queue_vec(-3, -4, 12);
    queue_vec(100, -200, 300);
    queue_vec(16384, 16384, 16384);
    queue_vec(21845, -10923, 4660);
    queue_random(180);

    // zero minimum: a zero vector is still too short
    write_min_length(32'd0);
    queue_vec(0, 0, 0);
    queue_vec(0, 1, 0);
    queue_random(120);

    wait_drained();
    send_idle_pct = 71;
    recv_idle_pct = 35;
    // top of range: only the largest vector passes
    write_min_length(32'hC000_0000);
    queue_vec(-32768, -32768, -32768);
    queue_vec(32767, 32767, 32767);
    queue_random(60);

    // threshold edge, equal passes and one below fails
    write_min_length(32'd25);
    queue_vec(0, 4, 3);
    queue_vec(2, 4, 2);
    queue_vec(-5, 0, 0);
    queue_vec(4, -2, -2);
    queue_random(140);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_min_length($urandom_range(32'h3FFF_FFFF, 32'h2000_0000));
    queue_random(150);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_units.size() == 0) begin
      $display("vector3_normalize_rsqrt_unit_tb: PASS");
    end else begin
      $display("vector3_normalize_rsqrt_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
